>>> rtl/core/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and constants shared by the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH  = 1024;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        LANE_HOLD   = 2'd0,
        LANE_INSERT = 2'd1,
        LANE_REMOVE = 2'd2,
        LANE_APPEND = 2'd3
    } lane_op_t;

    typedef struct packed {
        lane_op_t                  op;
        logic signed [DATA_W-1:0]  value;
        logic        [CNT_W-1:0]   count;
    } lane_ctrl_t;

    typedef struct packed {
        action_t                   action;
        logic signed [DATA_W-1:0]  value;
    } cmd_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  popped_value;
        logic signed [DATA_W-1:0]  front_value;
        logic signed [DATA_W-1:0]  back_value;
        logic        [CNT_W-1:0]   item_count;
        status_t                   status;
    } rsp_word_t;

endpackage

>>> rtl/core/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell of a lane: holds, shifts from a neighbor or loads a word.
// ----------------------------------------------------------------------------
module bdq_cell (
    input  logic                              clk,
    input  bdq_pkg::lane_ctrl_t               ctrl,
    input  logic [bdq_pkg::CNT_W-1:0]         cell_idx,
    input  logic signed [bdq_pkg::DATA_W-1:0] near_data,
    input  logic signed [bdq_pkg::DATA_W-1:0] far_data,
    output logic signed [bdq_pkg::DATA_W-1:0] data
);

    logic signed [bdq_pkg::DATA_W-1:0] data_reg;
    logic signed [bdq_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        case (ctrl.op)
            bdq_pkg::LANE_INSERT:
            begin
                data_next = (cell_idx == '0) ? ctrl.value : near_data;
            end
            bdq_pkg::LANE_REMOVE:
            begin
                data_next = far_data;
            end
            bdq_pkg::LANE_APPEND:
            begin
                data_next = (cell_idx == ctrl.count) ? ctrl.value : data_reg;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> rtl/core/bdq_lane.sv
// ----------------------------------------------------------------------------
// bdq_lane
// Row of cells with its end at cell 0; holds, shifts in, shifts out, or appends.
// ----------------------------------------------------------------------------
module bdq_lane (
    input  logic                              clk,
    input  bdq_pkg::lane_ctrl_t               ctrl,
    output logic signed [bdq_pkg::DATA_W-1:0] head
);

    logic signed [bdq_pkg::DATA_W-1:0] cell_data [bdq_pkg::DEPTH];

    for (genvar i = 0; i < bdq_pkg::DEPTH; i++)
    begin : g_cell
        logic signed [bdq_pkg::DATA_W-1:0] near_w;
        logic signed [bdq_pkg::DATA_W-1:0] far_w;

        if (i == 0)
        begin : g_first
            assign near_w = ctrl.value;
        end
        else
        begin : g_mid
            assign near_w = cell_data[i-1];
        end

        if (i == bdq_pkg::DEPTH - 1)
        begin : g_last
            assign far_w = cell_data[i];
        end
        else
        begin : g_body
            assign far_w = cell_data[i+1];
        end

        bdq_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .cell_idx  (bdq_pkg::CNT_W'(i)),
            .near_data (near_w),
            .far_data  (far_w),
            .data      (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule

>>> rtl/core/bounded_double_ended_queue.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Double-ended queue of signed words, up to DEPTH entries.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (action, value) is taken on a clock edge with start high
//   and busy low. busy stays low: a command may be issued every cycle.
//   Each command gives one response word on rsp, marked by done for exactly
//   one cycle, the cycle after the command was taken (one word per
//   cycle). The receiver cannot stall; it must take rsp when done is set.
//   Storage is two rows of cells. The front row keeps the front item in
//   cell 0 and the back row keeps the back item in cell 0, each row in
//   opposite order. A push shifts one row and writes the other at the cell
//   indexed by the count; a pop shifts one row, so both ends sit in cell 0.
//   Throughput is set by that single shift step: one command per cycle.
//   Pop on empty returns -1 with status EMPTY; push on full is dropped with
//   status FULL. front_value and back_value read -1 when the queue is empty.
//   Reset empties the queue at once (count to zero); no clearing pass.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bdq_pkg::cmd_word_t  cmd,
    output logic                done,
    output bdq_pkg::rsp_word_t  rsp
);

    bdq_pkg::lane_ctrl_t f_ctrl;
    bdq_pkg::lane_ctrl_t b_ctrl;
    logic signed [bdq_pkg::DATA_W-1:0] f_head;
    logic signed [bdq_pkg::DATA_W-1:0] b_head;

    logic [bdq_pkg::CNT_W-1:0]         count_reg;
    logic [bdq_pkg::CNT_W-1:0]         count_next;
    logic                              done_reg;
    logic signed [bdq_pkg::DATA_W-1:0] popped_reg;
    logic signed [bdq_pkg::DATA_W-1:0] popped_next;
    bdq_pkg::status_t                  status_reg;
    bdq_pkg::status_t                  status_next;

    logic accept;
    logic full;
    logic empty;

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign full   = (count_reg == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
    assign empty  = (count_reg == '0);

    always_comb
    begin
        f_ctrl.op    = bdq_pkg::LANE_HOLD;
        f_ctrl.value = cmd.value;
        f_ctrl.count = count_reg;
        b_ctrl.op    = bdq_pkg::LANE_HOLD;
        b_ctrl.value = cmd.value;
        b_ctrl.count = count_reg;
        count_next   = count_reg;
        popped_next  = '1;
        status_next  = bdq_pkg::ST_OK;
        if (accept)
        begin
            case (cmd.action)
                bdq_pkg::ACT_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = bdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        f_ctrl.op  = bdq_pkg::LANE_INSERT;
                        b_ctrl.op  = bdq_pkg::LANE_APPEND;
                        count_next = count_reg + bdq_pkg::CNT_W'(1);
                    end
                end
                bdq_pkg::ACT_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = bdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        f_ctrl.op  = bdq_pkg::LANE_APPEND;
                        b_ctrl.op  = bdq_pkg::LANE_INSERT;
                        count_next = count_reg + bdq_pkg::CNT_W'(1);
                    end
                end
                bdq_pkg::ACT_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = bdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        popped_next = f_head;
                        f_ctrl.op   = bdq_pkg::LANE_REMOVE;
                        count_next  = count_reg - bdq_pkg::CNT_W'(1);
                    end
                end
                bdq_pkg::ACT_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = bdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        popped_next = b_head;
                        b_ctrl.op   = bdq_pkg::LANE_REMOVE;
                        count_next  = count_reg - bdq_pkg::CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = bdq_pkg::ST_OK;
                end
            endcase
        end
    end

    bdq_lane u_front_lane (
        .clk  (clk),
        .ctrl (f_ctrl),
        .head (f_head)
    );

    bdq_lane u_back_lane (
        .clk  (clk),
        .ctrl (b_ctrl),
        .head (b_head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        status_reg <= status_next;
    end

    assign done              = done_reg;
    assign rsp.popped_value  = popped_reg;
    assign rsp.front_value   = empty ? '1 : f_head;
    assign rsp.back_value    = empty ? '1 : b_head;
    assign rsp.item_count    = count_reg;
    assign rsp.status        = status_reg;

    // occupancy never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
        else $error("count above capacity");

    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("missing response");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full && (cmd.action == bdq_pkg::ACT_PUSH_FRONT
                            || cmd.action == bdq_pkg::ACT_PUSH_BACK))
        |=> (count_reg == $past(count_reg)) && (rsp.status == bdq_pkg::ST_FULL))
        else $error("push on full changed the queue");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !empty && (cmd.action == bdq_pkg::ACT_POP_FRONT
                              || cmd.action == bdq_pkg::ACT_POP_BACK))
        |=> (count_reg == $past(count_reg) - bdq_pkg::CNT_W'(1)))
        else $error("pop did not decrement count");

endmodule

>>> tb/bdq_response_checker.sv
// ----------------------------------------------------------------------------
// bdq_response_checker
// Watches the command and response channels of the bounded double-ended
// queue, keeps its own copy of the queue state, predicts one response word
// per accepted command and compares every response word field by field
// against the oldest pending prediction.
// ----------------------------------------------------------------------------
module bdq_response_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  bdq_pkg::cmd_word_t  cmd,
    input  logic                done,
    input  bdq_pkg::rsp_word_t  rsp,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W     = $clog2(bdq_pkg::DEPTH);
    localparam int MAX_LINES = 40;
    localparam int EXP_DEPTH = 4;
    localparam int EXP_W     = $clog2(EXP_DEPTH);

    logic signed [bdq_pkg::DATA_W-1:0] shadow_ring [bdq_pkg::DEPTH];
    logic [IDX_W-1:0]                  head_slot;
    logic [IDX_W-1:0]                  tail_slot;
    logic [bdq_pkg::CNT_W-1:0]         shadow_level;
    bdq_pkg::rsp_word_t                expected_rsps [EXP_DEPTH];
    logic [EXP_W-1:0]                  exp_wr_ptr;
    logic [EXP_W-1:0]                  exp_rd_ptr;
    int                                exp_level;
    int                                mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(bdq_pkg::DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(bdq_pkg::DEPTH - 1) : i - IDX_W'(1);
    endfunction

    // applies one command to the shadow queue and returns the response word
    function automatic bdq_pkg::rsp_word_t predict_rsp(input bdq_pkg::cmd_word_t c);
        bdq_pkg::rsp_word_t r;
        r.popped_value = '1;
        r.status       = bdq_pkg::ST_OK;
        if (c.action == bdq_pkg::ACT_PUSH_FRONT || c.action == bdq_pkg::ACT_PUSH_BACK)
        begin
            if (shadow_level == bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
                r.status = bdq_pkg::ST_FULL;
            else if (c.action == bdq_pkg::ACT_PUSH_FRONT)
            begin
                head_slot              = slot_prev(head_slot);
                shadow_ring[head_slot] = c.value;
                shadow_level           = shadow_level + bdq_pkg::CNT_W'(1);
            end
            else
            begin
                shadow_ring[tail_slot] = c.value;
                tail_slot              = slot_next(tail_slot);
                shadow_level           = shadow_level + bdq_pkg::CNT_W'(1);
            end
        end
        else
        begin
            if (shadow_level == '0)
                r.status = bdq_pkg::ST_EMPTY;
            else if (c.action == bdq_pkg::ACT_POP_FRONT)
            begin
                r.popped_value = shadow_ring[head_slot];
                head_slot      = slot_next(head_slot);
                shadow_level   = shadow_level - bdq_pkg::CNT_W'(1);
            end
            else
            begin
                tail_slot      = slot_prev(tail_slot);
                r.popped_value = shadow_ring[tail_slot];
                shadow_level   = shadow_level - bdq_pkg::CNT_W'(1);
            end
        end
        if (shadow_level == '0)
        begin
            r.front_value = '1;
            r.back_value  = '1;
        end
        else
        begin
            r.front_value = shadow_ring[head_slot];
            r.back_value  = shadow_ring[slot_prev(tail_slot)];
        end
        r.item_count = shadow_level;
        return r;
    endfunction

    // output is capped so a broken block cannot flood the log
    task automatic report_mismatch(input string what,
                                   input logic [bdq_pkg::DATA_W-1:0] got,
                                   input logic [bdq_pkg::DATA_W-1:0] want);
        if (mismatches < MAX_LINES)
            $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic store_prediction(input bdq_pkg::rsp_word_t r);
        if (exp_level == EXP_DEPTH)
        begin
            report_mismatch("prediction overflow", '0, '0);
            return;
        end
        expected_rsps[exp_wr_ptr] = r;
        exp_wr_ptr                = exp_wr_ptr + EXP_W'(1);
        exp_level++;
    endtask

    task automatic compare_rsp(input bdq_pkg::rsp_word_t got);
        bdq_pkg::rsp_word_t want;
        if (exp_level == 0)
        begin
            report_mismatch("unexpected rsp word", bdq_pkg::DATA_W'(got.item_count), '0);
            return;
        end
        want       = expected_rsps[exp_rd_ptr];
        exp_rd_ptr = exp_rd_ptr + EXP_W'(1);
        exp_level--;
        if (got.popped_value !== want.popped_value)
            report_mismatch("popped_value", got.popped_value, want.popped_value);
        if (got.front_value !== want.front_value)
            report_mismatch("front_value", got.front_value, want.front_value);
        if (got.back_value !== want.back_value)
            report_mismatch("back_value", got.back_value, want.back_value);
        if (got.item_count !== want.item_count)
            report_mismatch("item_count", bdq_pkg::DATA_W'(got.item_count),
                            bdq_pkg::DATA_W'(want.item_count));
        if (got.status !== want.status)
            report_mismatch("status", bdq_pkg::DATA_W'(got.status),
                            bdq_pkg::DATA_W'(want.status));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_slot    = '0;
            tail_slot    = '0;
            shadow_level = '0;
            exp_wr_ptr   = '0;
            exp_rd_ptr   = '0;
            exp_level    = 0;
            pending <= 0;
        end
        else
        begin
            // response of an earlier word first, then the word taken now
            if (done)
                compare_rsp(rsp);
            if (start && !busy)
                store_prediction(predict_rsp(cmd));
            pending <= exp_level;
        end
    end

endmodule

>>> tb/bounded_double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_tb
// Drives command words into the bounded double-ended queue: a directed part
// on the empty queue and the value extremes, a random mix that hovers near
// empty, a fill to capacity with pushes at both ends against the full queue,
// and a final stretch without idle cycles. A separate checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    bdq_pkg::cmd_word_t cmd   = '0;
    logic               busy;
    logic               done;
    bdq_pkg::rsp_word_t rsp;
    int                 fail_count;
    int                 pending;

    int        idle_pct   = 0;
    int        level      = 0;
    int        peak_level = 0;
    int        words_sent = 0;
    int        empty_pops = 0;
    int        full_drops = 0;
    int        stall_run  = 0;

    bounded_double_ended_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    bdq_response_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .done       (done),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_run <= 0;
        else if (stall_run + 1 >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            stall_run <= stall_run + 1;
    end

    function automatic logic [bdq_pkg::DATA_W-1:0] rand_value();
        case ($urandom_range(7))
            0:       return {1'b1, {(bdq_pkg::DATA_W-1){1'b0}}};
            1:       return {1'b0, {(bdq_pkg::DATA_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic bdq_pkg::action_t rand_action(input int push_pct);
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? bdq_pkg::ACT_PUSH_BACK : bdq_pkg::ACT_PUSH_FRONT;
        return $urandom_range(1) ? bdq_pkg::ACT_POP_BACK : bdq_pkg::ACT_POP_FRONT;
    endfunction

    task automatic send_word(input bdq_pkg::action_t act,
                             input logic [bdq_pkg::DATA_W-1:0] val);
        int gap;
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 3);
            start      <= 1'b0;
            cmd.action <= bdq_pkg::action_t'($urandom_range(3));
            cmd.value  <= $urandom;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        cmd.action <= act;
        cmd.value  <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
        if (act == bdq_pkg::ACT_PUSH_FRONT || act == bdq_pkg::ACT_PUSH_BACK)
        begin
            if (level == bdq_pkg::DEPTH)
                full_drops++;
            else
                level++;
        end
        else if (level == 0)
            empty_pops++;
        else
            level--;
        if (level > peak_level)
            peak_level = level;
    endtask

    task automatic drain_queue();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pops, value extremes, emptying from either end
        idle_pct = 25;
        send_word(bdq_pkg::ACT_POP_FRONT, 32'h1234_5678);
        send_word(bdq_pkg::ACT_POP_BACK, 32'h8765_4321);
        send_word(bdq_pkg::ACT_PUSH_BACK, 32'hFFFF_FFFF);
        send_word(bdq_pkg::ACT_POP_FRONT, '0);
        send_word(bdq_pkg::ACT_PUSH_FRONT, 32'h7FFF_FFFF);
        send_word(bdq_pkg::ACT_PUSH_BACK, 32'h8000_0000);
        send_word(bdq_pkg::ACT_PUSH_FRONT, 32'h0000_0000);
        send_word(bdq_pkg::ACT_PUSH_BACK, 32'hFFFF_FFFF);
        send_word(bdq_pkg::ACT_POP_FRONT, '1);
        send_word(bdq_pkg::ACT_POP_BACK, '1);
        send_word(bdq_pkg::ACT_POP_BACK, '0);
        send_word(bdq_pkg::ACT_POP_FRONT, '0);
        send_word(bdq_pkg::ACT_POP_FRONT, '0);
        send_word(bdq_pkg::ACT_PUSH_BACK, 32'h0000_0001);
        send_word(bdq_pkg::ACT_POP_FRONT, '0);
        send_word(bdq_pkg::ACT_PUSH_FRONT, 32'h0000_0005);
        send_word(bdq_pkg::ACT_POP_BACK, '0);
        send_word(bdq_pkg::ACT_PUSH_FRONT, 32'h5555_5555);
        send_word(bdq_pkg::ACT_PUSH_FRONT, 32'hAAAA_AAAA);
        send_word(bdq_pkg::ACT_POP_FRONT, '0);
        send_word(bdq_pkg::ACT_POP_FRONT, '0);
        send_word(bdq_pkg::ACT_POP_BACK, '0);
        drain_queue();

        // balanced mix, stays near empty
        idle_pct = 30;
        repeat (250)
            send_word(rand_action(50), rand_value());
        drain_queue();

        // fill to capacity, then work against the full queue
        idle_pct = 15;
        while (level < bdq_pkg::DEPTH)
            send_word(rand_action(95), rand_value());
        repeat (40)
            send_word(rand_action(70), rand_value());
        drain_queue();

        // back-to-back words, pop-heavy
        idle_pct = 0;
        repeat (250)
            send_word(rand_action(40), rand_value());
        start <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("sent %0d command words: pushes and pops at both ends, peak level %0d of %0d",
                 words_sent, peak_level, bdq_pkg::DEPTH);
        $display("pops on empty queue: %0d, pushes dropped on full queue: %0d",
                 empty_pops, full_drops);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/bdq_pkg.sv
rtl/core/bdq_cell.sv
rtl/core/bdq_lane.sv
rtl/core/bounded_double_ended_queue.sv
tb/bdq_response_checker.sv
tb/bounded_double_ended_queue_tb.sv
